/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, run and match codes, lexer state layout and result layout.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Sizing
   localparam int MAX_TOKEN   = 64;
   localparam int POS_BITS    = 32;
   localparam int LEN_BITS    = $clog2(MAX_TOKEN + 1);
   localparam int CH_BITS     = 8;
   localparam int MAX_RESULTS = 2;

   // Result queue
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   // Stream word layout
   localparam int RSP_FIELD_BITS = 3 + 32 + 7 + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   // Typed constants
   localparam logic [LEN_BITS-1:0]  LEN_MAX    = LEN_BITS'(MAX_TOKEN);
   localparam logic [LEN_BITS-1:0]  LEN_ONE    = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0]  LEN_TWO    = LEN_BITS'(2);
   localparam logic [POS_BITS-1:0]  POS_ONE    = POS_BITS'(1);
   localparam logic [QCNT_BITS-1:0] QCNT_FULL  = QCNT_BITS'(QDEPTH);
   localparam logic [QCNT_BITS-1:0] QCNT_ROOM  = QCNT_BITS'(QDEPTH - MAX_RESULTS);

   // Control characters: LF and SI end a comment, HT, LF and CR are white space
   localparam logic [CH_BITS-1:0] CH_LF = 8'h0A;
   localparam logic [CH_BITS-1:0] CH_SI = 8'h0F;
   localparam logic [CH_BITS-1:0] CH_CR = 8'h0D;
   localparam logic [CH_BITS-1:0] CH_HT = 8'h09;

   typedef enum logic [2:0] {
      KIND_DATATYPE = 3'd0,
      KIND_IDENT    = 3'd1,
      KIND_PUNCT    = 3'd2,
      KIND_OPER     = 3'd3,
      KIND_KEYWORD  = 3'd4,
      KIND_LITERAL  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_WORD = 2'd1,
      RUN_OPER = 2'd2
   } run_type;

   // Keyword matcher: "ret" and "if"
   typedef enum logic [2:0] {
      KW_START = 3'd0,
      KW_R     = 3'd1,
      KW_RE    = 3'd2,
      KW_RET   = 3'd3,
      KW_I     = 3'd4,
      KW_IF    = 3'd5,
      KW_FAIL  = 3'd6
   } kw_type;

   // Literal matcher: digits, digits.digits, quoted string
   typedef enum logic [2:0] {
      LIT_START   = 3'd0,
      LIT_INT     = 3'd1,
      LIT_DOT     = 3'd2,
      LIT_FRAC    = 3'd3,
      LIT_STR     = 3'd4,
      LIT_STR_END = 3'd5,
      LIT_FAIL    = 3'd6
   } lit_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [6:0]  length;
      logic        clip;
      logic        last;
   } tok_desc_type;

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      run_type             open_class;
      logic [POS_BITS-1:0] open_start;
      logic [LEN_BITS-1:0] open_length;
      logic                open_clip;
      logic                op_slash;
      kw_type              kw;
      lit_type             lit;
      logic                in_comment;
      logic                held_valid;
      kind_type            held_kind;
      logic [POS_BITS-1:0] held_start;
      logic [LEN_BITS-1:0] held_length;
      logic                held_clip;
      logic                held_final;
      logic                any_emitted;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '0;

   // Tokens produced by one step of the lexer
   typedef struct packed {
      logic [1:0]   count;
      tok_desc_type tok0;
      tok_desc_type tok1;
   } emit_type;

   // Result queue status toward the input side
   typedef struct packed {
      logic                 not_empty;
      logic                 room;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

endpackage

/* src/stt_lexer.sv */
// ----------------------------------------------------------------------------
// stt_lexer: per-byte lexer step and lexer state register
// Classifies one byte, grows or closes the open run, types words and emits
// up to two finished tokens per step. The newest token is held back until the
// next token or end of text so a following word can retype an identifier as a datatype.
// ----------------------------------------------------------------------------
module stt_lexer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [stt_pkg::CH_BITS-1:0] ch,
   input  logic                        eot,
   output stt_pkg::emit_type           emit
);

   typedef struct packed {
      stt_pkg::lex_state_type st;
      logic                   valid;
      stt_pkg::tok_desc_type  tok;
      logic                   comment;
   } fin_type;

   stt_pkg::lex_state_type state_ff;
   stt_pkg::lex_state_type state_in;
   stt_pkg::emit_type      emit_all;

   // Character classes
   function automatic logic is_oper(logic [7:0] c);
      return c inside {"+", "-", "=", ">", "<", "*", "/", "!", "|", "&", "^"};
   endfunction

   function automatic logic is_name(logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_", "\"", "'", ".", "\\",
                       "[", "]", "(", ")"};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || c == stt_pkg::CH_HT || c == stt_pkg::CH_LF ||
             c == stt_pkg::CH_CR;
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return c inside {";", "{", "}"};
   endfunction

   // Keyword matcher step
   function automatic stt_pkg::kw_type kw_next(stt_pkg::kw_type s, logic [7:0] c);
      stt_pkg::kw_type r;
      r = stt_pkg::KW_FAIL;
      case (s)
         stt_pkg::KW_START: begin
            if (c == "r") r = stt_pkg::KW_R;
            else if (c == "i") r = stt_pkg::KW_I;
         end
         stt_pkg::KW_R:  if (c == "e") r = stt_pkg::KW_RE;
         stt_pkg::KW_RE: if (c == "t") r = stt_pkg::KW_RET;
         stt_pkg::KW_I:  if (c == "f") r = stt_pkg::KW_IF;
         default: r = stt_pkg::KW_FAIL;
      endcase
      return r;
   endfunction

   // Literal matcher step
   function automatic stt_pkg::lit_type lit_next(stt_pkg::lit_type s, logic [7:0] c);
      stt_pkg::lit_type r;
      logic             d;
      d = (c >= "0") && (c <= "9");
      r = stt_pkg::LIT_FAIL;
      case (s) inside
         stt_pkg::LIT_START: begin
            if (d) r = stt_pkg::LIT_INT;
            else if (c == "\"") r = stt_pkg::LIT_STR;
         end
         stt_pkg::LIT_INT: begin
            if (d) r = stt_pkg::LIT_INT;
            else if (c == ".") r = stt_pkg::LIT_DOT;
         end
         stt_pkg::LIT_DOT, stt_pkg::LIT_FRAC: if (d) r = stt_pkg::LIT_FRAC;
         stt_pkg::LIT_STR, stt_pkg::LIT_STR_END: begin
            r = (c == "\"") ? stt_pkg::LIT_STR_END : stt_pkg::LIT_STR;
         end
         default: r = stt_pkg::LIT_FAIL;
      endcase
      return r;
   endfunction

   function automatic stt_pkg::tok_desc_type make_tok(stt_pkg::kind_type kind,
                                                   logic [stt_pkg::POS_BITS-1:0] start,
                                                   logic [stt_pkg::LEN_BITS-1:0] len,
                                                   logic clip, logic last);
      stt_pkg::tok_desc_type t;
      t.kind   = kind;
      t.start  = 32'(start);
      t.length = 7'(len);
      t.clip   = clip;
      t.last   = last;
      return t;
   endfunction

   // Place a finished token in the hold slot, releasing the previous one
   function automatic fin_type finish_fn(stt_pkg::lex_state_type s, stt_pkg::kind_type kind,
                                         logic ctx, logic [stt_pkg::POS_BITS-1:0] start,
                                         logic [stt_pkg::LEN_BITS-1:0] len, logic clip);
      fin_type           r;
      stt_pkg::kind_type k;
      r.st      = s;
      r.comment = 1'b0;
      k         = kind;
      if (ctx) begin
         if (!s.any_emitted) begin
            k = stt_pkg::KIND_DATATYPE;
         end else if (s.held_valid && s.held_kind == stt_pkg::KIND_IDENT) begin
            // previous identifier turns out to be a datatype
            r.st.held_kind = stt_pkg::KIND_DATATYPE;
            k = stt_pkg::KIND_IDENT;
         end else begin
            k = stt_pkg::KIND_IDENT;
         end
      end
      r.valid = s.held_valid;
      r.tok   = make_tok(r.st.held_kind, s.held_start, s.held_length, s.held_clip, 1'b0);
      r.st.held_valid  = 1'b1;
      r.st.held_final  = 1'b0;
      r.st.held_kind   = k;
      r.st.held_start  = start;
      r.st.held_length = len;
      r.st.held_clip   = clip;
      r.st.any_emitted = 1'b1;
      return r;
   endfunction

   // Close the open run; flag a bare "//" as a comment opener
   function automatic fin_type close_fn(stt_pkg::lex_state_type s);
      fin_type r;
      r.st            = s;
      r.st.open_class = stt_pkg::RUN_NONE;
      r.valid         = 1'b0;
      r.tok           = '0;
      r.comment       = 1'b0;
      if (s.open_class == stt_pkg::RUN_OPER) begin
         if (s.op_slash && s.open_length == stt_pkg::LEN_TWO && !s.open_clip) begin
            r.comment = 1'b1;
         end else begin
            r = finish_fn(r.st, stt_pkg::KIND_OPER, 1'b0, s.open_start, s.open_length,
                          s.open_clip);
         end
      end else if (s.open_class == stt_pkg::RUN_WORD) begin
         if (s.kw == stt_pkg::KW_RET || s.kw == stt_pkg::KW_IF) begin
            r = finish_fn(r.st, stt_pkg::KIND_KEYWORD, 1'b0, s.open_start, s.open_length,
                          s.open_clip);
         end else if (s.lit == stt_pkg::LIT_INT || s.lit == stt_pkg::LIT_FRAC ||
                      s.lit == stt_pkg::LIT_STR_END) begin
            r = finish_fn(r.st, stt_pkg::KIND_LITERAL, 1'b0, s.open_start, s.open_length,
                          s.open_clip);
         end else begin
            r = finish_fn(r.st, stt_pkg::KIND_DATATYPE, 1'b1, s.open_start, s.open_length,
                          s.open_clip);
         end
      end
      return r;
   endfunction

   // Add one byte to the run, opening a new one first when asked
   function automatic stt_pkg::lex_state_type grow_fn(stt_pkg::lex_state_type s,
                                                      logic [7:0] c, logic fresh);
      stt_pkg::lex_state_type r;
      r = s;
      if (fresh) begin
         r.open_start  = s.position;
         r.open_length = '0;
         r.open_clip   = 1'b0;
         r.op_slash    = 1'b1;
         r.kw          = stt_pkg::KW_START;
         r.lit         = stt_pkg::LIT_START;
      end
      if (r.open_length < stt_pkg::LEN_MAX) r.open_length = r.open_length + stt_pkg::LEN_ONE;
      else r.open_clip = 1'b1;
      if (c != "/") r.op_slash = 1'b0;
      r.kw  = kw_next(r.kw, c);
      r.lit = lit_next(r.lit, c);
      return r;
   endfunction

   // Append a token to the step's output, dropping any beyond two
   function automatic stt_pkg::emit_type push_fn(stt_pkg::emit_type e,
                                                 stt_pkg::tok_desc_type t);
      stt_pkg::emit_type r;
      r = e;
      if (e.count == 2'd0) begin
         r.tok0  = t;
         r.count = 2'd1;
      end else if (e.count == 2'd1) begin
         r.tok1  = t;
         r.count = 2'd2;
      end
      return r;
   endfunction

   // One lexer step
   always_comb begin
      stt_pkg::lex_state_type s;
      stt_pkg::emit_type      e;
      fin_type                f;
      fin_type                g;
      stt_pkg::run_type       cls;
      s   = state_ff;
      e   = '0;
      f   = '0;
      g   = '0;
      cls = is_oper(ch) ? stt_pkg::RUN_OPER : stt_pkg::RUN_WORD;

      // release a final token left over from the previous text
      if (s.held_valid && s.held_final) begin
         e = push_fn(e, make_tok(s.held_kind, s.held_start, s.held_length, s.held_clip, 1'b1));
         s.held_valid = 1'b0;
         s.held_final = 1'b0;
      end

      if (s.in_comment) begin
         if (ch == stt_pkg::CH_LF || ch == stt_pkg::CH_SI) s.in_comment = 1'b0;
      end else if (is_oper(ch) || is_name(ch)) begin
         if (s.open_class != cls) begin
            f = close_fn(s);
            s = f.st;
            if (f.valid) e = push_fn(e, f.tok);
            if (f.comment) begin
               s.in_comment = 1'b1;
            end else begin
               s = grow_fn(s, ch, 1'b1);
               s.open_class = cls;
            end
         end else begin
            s = grow_fn(s, ch, 1'b0);
         end
      end else if (is_space(ch) || is_punct(ch)) begin
         f = close_fn(s);
         s = f.st;
         if (f.valid) e = push_fn(e, f.tok);
         if (f.comment) begin
            s.in_comment = 1'b1;
         end else if (is_punct(ch)) begin
            g = finish_fn(s, stt_pkg::KIND_PUNCT, 1'b0, s.position, stt_pkg::LEN_ONE, 1'b0);
            s = g.st;
            if (g.valid) e = push_fn(e, g.tok);
         end
      end

      s.position = s.position + stt_pkg::POS_ONE;

      // flush at end of text and return to the start of a new text
      if (eot) begin
         f = close_fn(s);
         s = f.st;
         if (f.valid) e = push_fn(e, f.tok);
         if (s.held_valid) begin
            if (e.count != 2'd2) begin
               e = push_fn(e, make_tok(s.held_kind, s.held_start, s.held_length,
                                       s.held_clip, 1'b1));
               s.held_valid = 1'b0;
            end else begin
               s.held_final = 1'b1;
            end
         end
         s.in_comment  = 1'b0;
         s.any_emitted = 1'b0;
         s.position    = '0;
         s.open_class  = stt_pkg::RUN_NONE;
         s.open_length = '0;
         s.open_clip   = 1'b0;
         s.kw          = stt_pkg::KW_START;
         s.lit         = stt_pkg::LIT_START;
      end

      state_in = step ? s : state_ff;
      emit_all = e;
   end

   // Drive tokens only on a real step
   always_comb begin
      emit = emit_all;
      if (!step) emit.count = 2'd0;
   end

   // Lexer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::LEX_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/stt_result_queue.sv */
// ----------------------------------------------------------------------------
// stt_result_queue: small token queue in front of the result port
// Takes zero, one or two tokens per cycle and hands out one per cycle while the result port accepts.
// Reports room when two more tokens fit after this cycle's pop.
// ----------------------------------------------------------------------------
module stt_result_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  stt_pkg::emit_type           push,
   input  logic                        pop,
   output stt_pkg::tok_desc_type       head,
   output stt_pkg::queue_status_type   status
);

   localparam logic [stt_pkg::QPTR_BITS-1:0] QPTR_ONE = stt_pkg::QPTR_BITS'(1);
   localparam logic [stt_pkg::QPTR_BITS-1:0] QPTR_TWO = stt_pkg::QPTR_BITS'(2);

   stt_pkg::tok_desc_type               entry_ff [stt_pkg::QDEPTH];
   logic [stt_pkg::QPTR_BITS-1:0]       wr_ptr_ff;
   logic [stt_pkg::QPTR_BITS-1:0]       wr_ptr_in;
   logic [stt_pkg::QPTR_BITS-1:0]       rd_ptr_ff;
   logic [stt_pkg::QPTR_BITS-1:0]       rd_ptr_in;
   logic [stt_pkg::QCNT_BITS-1:0]       count_ff;
   logic [stt_pkg::QCNT_BITS-1:0]       count_in;
   logic [stt_pkg::QCNT_BITS-1:0]       after_pop;

   // Pointer and fill count update
   always_comb begin
      after_pop = count_ff - stt_pkg::QCNT_BITS'(pop);
      count_in  = after_pop + stt_pkg::QCNT_BITS'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_ONE : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_ff + QPTR_ONE;
         2'd2:    wr_ptr_in = wr_ptr_ff + QPTR_TWO;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming tokens
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.tok0;
      if (push.count == 2'd2) entry_ff[wr_ptr_ff + QPTR_ONE] <= push.tok1;
   end

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room      = (after_pop <= stt_pkg::QCNT_ROOM);
   assign status.count     = count_ff;

endmodule

/* src/source_text_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: byte-serial lexer for a small source language
// Takes one text byte per word and returns token descriptors (kind, start,
// length, clip flag) with tlast on the final token of each text.
//
//   channel  dir  tdata                         tlast
//   req_     in   [7:0] ch                      end_of_text
//   rsp_     out  kind, start, length, clip     last_token
//
// A byte is taken every cycle while the result queue has room for two tokens.
// A byte waits in the input register until a lexer step takes it; that
// step's tokens appear on rsp_ at the earliest in the cycle after it.
// The result queue (4 tokens) decouples a stalled rsp_ side from req_.
// Reset is synchronous and empties the input register, lexer state and queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core (
   input  logic                              clock,
   input  logic                              reset,
   // [7:0] ch
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] token_kind, [34:3] token_start, [41:35] token_length,
   // [42] length_clipped, [47:43] zero
   output logic [stt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [stt_pkg::CH_BITS-1:0] in_ch_ff;
   logic                        in_eot_ff;
   logic                        req_accept;
   logic                        step;
   logic                        pop;
   stt_pkg::emit_type           lex_emit;
   stt_pkg::tok_desc_type       q_head;
   stt_pkg::queue_status_type   q_status;

   // Input register handshake
   assign step       = in_valid_ff && q_status.room;
   assign req_tready = !in_valid_ff || step;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the byte until the lexer takes it
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ch_ff  <= req_tdata;
         in_eot_ff <= req_tlast;
      end
   end

   stt_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ch    (in_ch_ff),
      .eot   (in_eot_ff),
      .emit  (lex_emit)
   );

   assign pop = rsp_tvalid && rsp_tready;

   stt_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (lex_emit),
      .pop    (pop),
      .head   (q_head),
      .status (q_status)
   );

   // Pack the result word
   assign rsp_tvalid = q_status.not_empty;
   assign rsp_tlast  = q_head.last;
   assign rsp_tdata  = {{stt_pkg::RSP_PAD_BITS{1'b0}}, q_head.clip, q_head.length,
                        q_head.start, q_head.kind};

`ifndef NO_ASSERTIONS
   queue_bound_a: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= stt_pkg::QCNT_FULL)
      else $error("result queue holds more tokens than its depth");

   token_visible_a: assert property (@(posedge clock) disable iff (reset)
      (step && lex_emit.count != 2'd0) |=> rsp_tvalid)
      else $error("token from a lexer step did not reach the result port");

   token_sane_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (q_head.kind <= stt_pkg::KIND_LITERAL && q_head.length != 7'd0))
      else $error("result token has a bad kind or zero length");
`endif

endmodule
